// ===== design/delay_queue_top_defines.svh =====
// Assertion macros shared by the delay queue RTL.
`ifndef DELAY_QUEUE_TOP_DEFINES_SVH
`define DELAY_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the block clock outside reset.
`define DQ_CHK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on the block clock outside reset.
`define DQ_CHK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DQ_CHK_IMP(lbl, ante, cons, msg)
`define DQ_CHK_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/dq_pkg.sv =====
// Types and codes shared by the delay queue controller and datapath.
`default_nettype none
package dq_pkg;

    // Input beat kinds.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_POLL  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NOT_DUE = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    exec_tick;
        logic    exec_add;
        logic    exec_clear;
        logic    scan_start;
        logic    scan_run;
        logic    take;
        logic    shift_start;
        logic    shift_run;
        logic    count_dec;
        logic    load_out;
        status_t status;
    } dq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  empty;
        logic  full;
        logic  scan_done;
        logic  head_due;
        logic  shift_done;
        logic  out_free;
    } dq_sts_t;

endpackage
`default_nettype wire

// ===== design/dq_ctrl.sv =====
// Sequencing state machine of the delay queue.
`default_nettype none
module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire dq_sts_t sts,
    output dq_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    logic    poll_reg, poll_next;
    status_t status_reg, status_next;

    // State and per-beat bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            poll_reg   <= 1'b0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            poll_reg   <= poll_next;
            status_reg <= status_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        poll_next   = poll_reg;
        status_next = status_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept  = 1'b1;
                    status_next = ST_OK;
                    poll_next   = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (sts.kind)
                    KIND_TICK:  cmd.exec_tick = 1'b1;
                    KIND_ADD: begin
                        if (sts.full) begin
                            status_next = ST_FULL;
                        end else begin
                            cmd.exec_add = 1'b1;
                        end
                    end
                    KIND_POLL: begin
                        if (sts.empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            poll_next = 1'b1;
                        end
                    end
                    KIND_CLEAR: cmd.exec_clear = 1'b1;
                    default:    cmd.exec_clear = 1'b0;
                endcase
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    if (poll_reg) begin
                        poll_next = 1'b0;
                        if (sts.head_due) begin
                            cmd.take        = 1'b1;
                            cmd.shift_start = 1'b1;
                            state_next      = S_SHIFT;
                        end else begin
                            status_next = ST_NOT_DUE;
                            state_next  = S_DONE;
                        end
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                cmd.shift_run = 1'b1;
                if (sts.shift_done) begin
                    cmd.count_dec  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        cmd.status = status_next;
    end

endmodule
`default_nettype wire

// ===== design/dq_datapath.sv =====
// Entry store, time counter, head scan, gap close and result register of the delay queue.
`default_nettype none
`include "delay_queue_top_defines.svh"
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dq_cmd_t            cmd,
    output dq_sts_t                 sts,
    input  wire logic [1:0]         s_kind,
    input  wire logic [31:0]        s_item_in,
    input  wire logic [30:0]        s_delay,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [31:0]             m_item_out,
    output logic                    m_item_valid,
    output logic [4:0]              m_occupancy,
    output logic signed [31:0]      m_time_to_next
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [TIME_WIDTH-1:0] TSIGN = {1'b1, {(TIME_WIDTH-1){1'b0}}};

    // Latched input beat and architectural state.
    kind_t                  kind_reg;
    logic [VALUE_WIDTH-1:0] item_reg;
    logic [30:0]            delay_reg;
    logic [TIME_WIDTH-1:0]  now_reg;
    logic [CW-1:0]          count_reg;

    // Entry store with registered read.
    logic [TIME_WIDTH-1:0]  exp_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
    logic [TIME_WIDTH-1:0]  rd_exp_reg;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic [AW-1:0]          rd_addr;
    logic                   we;
    logic [AW-1:0]          wa;
    logic [TIME_WIDTH-1:0]  wexp;
    logic [VALUE_WIDTH-1:0] wval;

    // Head scan.
    logic [CW-1:0]          idx_reg;
    logic                   pv_reg;
    logic [AW-1:0]          pidx_reg;
    logic [TIME_WIDTH-1:0]  best_key_reg;
    logic [AW-1:0]          best_idx_reg;
    logic [VALUE_WIDTH-1:0] best_val_reg;
    logic [TIME_WIDTH-1:0]  key;

    // Gap close after a removal.
    logic [CW-1:0]          sh_reg;
    logic                   wp_reg;
    logic [AW-1:0]          wa_reg;

    // Taken value and result register.
    logic [VALUE_WIDTH-1:0] tk_val_reg;
    logic                   tk_v_reg;
    logic                   m_valid_reg;
    logic [1:0]             o_status_reg;
    logic [31:0]            o_item_reg;
    logic                   o_ivalid_reg;
    logic [4:0]             o_occ_reg;
    logic [31:0]            o_ttn_reg;
    logic [TIME_WIDTH-1:0]  head_diff;
    logic [31:0]            ttn;
    logic                   full;

    assign full = (count_reg == CW'(DEPTH));

    // Input beat capture.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg  <= kind_t'(s_kind);
            item_reg  <= VALUE_WIDTH'(s_item_in);
            delay_reg <= s_delay;
        end
    end

    // Time counter and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.exec_tick) begin
                now_reg <= now_reg + 1'b1;
            end
            if (cmd.exec_add) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.exec_clear) begin
                count_reg <= '0;
            end else if (cmd.count_dec) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Write port: append on add, move down during gap close.
    always_comb begin
        we   = 1'b0;
        wa   = wa_reg;
        wexp = rd_exp_reg;
        wval = rd_val_reg;
        if (cmd.exec_add) begin
            we   = 1'b1;
            wa   = count_reg[AW-1:0];
            wexp = now_reg + TIME_WIDTH'(delay_reg);
            wval = item_reg;
        end else if (wp_reg) begin
            we = 1'b1;
        end
    end

    assign rd_addr = cmd.shift_run ? sh_reg[AW-1:0] : idx_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (we) begin
            exp_mem[wa] <= wexp;
            val_mem[wa] <= wval;
        end
        rd_exp_reg <= exp_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    // Biased wrap-safe key: unsigned compare orders expiry minus now.
    assign key = (rd_exp_reg - now_reg) ^ TSIGN;

    // Scan one entry a cycle; strict less keeps the oldest on ties.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            pv_reg  <= 1'b0;
        end else if (cmd.scan_start) begin
            idx_reg <= '0;
            pv_reg  <= 1'b0;
        end else if (cmd.scan_run) begin
            if (idx_reg < count_reg) begin
                idx_reg <= idx_reg + 1'b1;
                pv_reg  <= 1'b1;
            end else begin
                pv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_run) begin
            pidx_reg <= idx_reg[AW-1:0];
            if (pv_reg && (pidx_reg == '0 || key < best_key_reg)) begin
                best_key_reg <= key;
                best_idx_reg <= pidx_reg;
                best_val_reg <= rd_val_reg;
            end
        end
    end

    // Gap close: read entry i+1, write it to i on the next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sh_reg <= '0;
            wp_reg <= 1'b0;
        end else if (cmd.shift_start) begin
            sh_reg <= CW'(best_idx_reg) + 1'b1;
            wp_reg <= 1'b0;
        end else if (cmd.shift_run) begin
            if (sh_reg < count_reg) begin
                sh_reg <= sh_reg + 1'b1;
                wp_reg <= 1'b1;
            end else begin
                wp_reg <= 1'b0;
            end
        end else begin
            wp_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift_run) begin
            wa_reg <= AW'(sh_reg - 1'b1);
        end
    end

    // Value removed by a poll.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tk_v_reg <= 1'b0;
        end else if (cmd.accept) begin
            tk_v_reg <= 1'b0;
        end else if (cmd.take) begin
            tk_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            tk_val_reg <= best_val_reg;
        end
    end

    // Time to the earliest expiry, saturated to the result field.
    always_comb begin
        head_diff = best_key_reg ^ TSIGN;
        if (count_reg == '0) begin
            ttn = 32'hFFFF_FFFF;
        end else if (head_diff[TIME_WIDTH-1] || head_diff == '0) begin
            ttn = '0;
        end else if (64'(head_diff) > 64'h7FFF_FFFF) begin
            ttn = 32'h7FFF_FFFF;
        end else begin
            ttn = 32'(head_diff);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            o_status_reg <= cmd.status;
            o_item_reg   <= tk_v_reg ? 32'(tk_val_reg) : 32'd0;
            o_ivalid_reg <= tk_v_reg;
            o_occ_reg    <= 5'(count_reg);
            o_ttn_reg    <= ttn;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = o_status_reg;
    assign m_item_out     = o_item_reg;
    assign m_item_valid   = o_ivalid_reg;
    assign m_occupancy    = o_occ_reg;
    assign m_time_to_next = $signed(o_ttn_reg);

    // Status to the controller.
    always_comb begin
        sts.kind       = kind_reg;
        sts.empty      = (count_reg == '0);
        sts.full       = full;
        sts.scan_done  = !pv_reg && (idx_reg >= count_reg);
        sts.head_due   = (best_key_reg <= TSIGN);
        sts.shift_done = !wp_reg && (sh_reg >= count_reg);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // Checks.
    `DQ_CHK_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "occupancy above depth")
    `DQ_CHK_IMP(a_no_overwrite, cmd.load_out, !m_valid_reg || m_ready, "result overwritten")
    `DQ_CHK_IMP(a_take_nonempty, cmd.take, count_reg != '0, "poll removal from empty store")
    `DQ_CHK_NXT(a_add_grows, cmd.exec_add, count_reg != '0, "add left store empty")

endmodule
`default_nettype wire

// ===== design/delay_queue_top.sv =====
// Delay queue: bounded store ordered by wrap-safe expiry time.
// Tick, add and clear give m_valid after acceptance and one linear head scan over the store.
// A successful poll gives it after a scan, a gap close and a rescan.
// Throughput: one beat at a time; the next beat is taken while a result waits in the output register.
// Reset (aresetn, synchronous, active low) clears time, occupancy and control; the store is not cleared.
`default_nettype none
module delay_queue_top
    import dq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic [31:0]        s_item_in,
    input  wire logic [30:0]        s_delay,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [31:0]             m_item_out,
    output logic                    m_item_valid,
    output logic [4:0]              m_occupancy,
    output logic signed [31:0]      m_time_to_next
);

    dq_cmd_t cmd;
    dq_sts_t sts;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dq_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_kind         (s_kind),
        .s_item_in      (s_item_in),
        .s_delay        (s_delay),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_item_out     (m_item_out),
        .m_item_valid   (m_item_valid),
        .m_occupancy    (m_occupancy),
        .m_time_to_next (m_time_to_next)
    );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the delay queue: random kinds, delays and values with gaps.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import dq_pkg::*;

    localparam int NUM_ITEMS   = 1250;
    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 1000000;

    // One result beat as the block reports it.
    typedef struct packed {
        status_t     status;
        logic [31:0] item_out;
        logic        item_valid;
        logic [4:0]  occupancy;
        logic [31:0] time_to_next;
    } dq_result_t;

    // Tracks the expected store contents and the results still owed by the block.
    class dq_scoreboard;
        logic [31:0]  now_ms;
        logic [31:0]  expiry_q[$];
        logic [31:0]  value_q[$];
        dq_result_t   pending_q[$];
        int           mismatches;

        function new();
            now_ms     = '0;
            mismatches = 0;
        endfunction

        // Signed distance to expiry, biased so an unsigned compare orders it.
        function logic [31:0] expiry_key(logic [31:0] expiry);
            return (expiry - now_ms) ^ 32'h8000_0000;
        endfunction

        function int earliest_index();
            int best;
            best = 0;
            for (int i = 1; i < expiry_q.size(); i++) begin
                if (expiry_key(expiry_q[i]) < expiry_key(expiry_q[best])) begin
                    best = i;
                end
            end
            return best;
        endfunction

        // Applies one accepted input beat and queues the expected result.
        function void note_input(kind_t kind, logic [31:0] value, logic [30:0] delay);
            dq_result_t res;
            int         head;
            logic [31:0] remain;
            res = '0;
            res.status = ST_OK;
            case (kind)
                KIND_TICK: begin
                    now_ms = now_ms + 1;
                end
                KIND_ADD: begin
                    if (expiry_q.size() >= DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        expiry_q.insert(expiry_q.size(), now_ms + {1'b0, delay});
                        value_q.insert(value_q.size(), value);
                    end
                end
                KIND_POLL: begin
                    if (expiry_q.size() == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        head = earliest_index();
                        if (expiry_key(expiry_q[head]) > 32'h8000_0000) begin
                            res.status = ST_NOT_DUE;
                        end else begin
                            res.item_out   = value_q[head];
                            res.item_valid = 1'b1;
                            expiry_q.delete(head);
                            value_q.delete(head);
                        end
                    end
                end
                default: begin
                    expiry_q.delete();
                    value_q.delete();
                end
            endcase
            res.occupancy = 5'(expiry_q.size());
            if (expiry_q.size() == 0) begin
                res.time_to_next = 32'hFFFF_FFFF;
            end else begin
                remain = expiry_q[earliest_index()] - now_ms;
                res.time_to_next = remain[31] ? 32'd0 : remain;
            end
            pending_q.insert(pending_q.size(), res);
        endfunction

        // Compares one result beat with the oldest expectation.
        function void check_result(dq_result_t got);
            dq_result_t want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result beat %p", got);
                end
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch: expected %p, got %p", want, got);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [31:0] s_item_in;
    logic [30:0] s_delay;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_item_out;
    logic        m_item_valid;
    logic [4:0]  m_occupancy;
    logic signed [31:0] m_time_to_next;

    dq_scoreboard board;
    int           cycles;
    bit           sink_calm;

    delay_queue_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_item_in      (s_item_in),
        .s_delay        (s_delay),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_item_out     (m_item_out),
        .m_item_valid   (m_item_valid),
        .m_occupancy    (m_occupancy),
        .m_time_to_next (m_time_to_next)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one.
    function int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drives one beat from the falling edge and notes it once accepted.
    // Valid stays high on return so that a beat with no gap follows directly.
    task automatic send_beat(kind_t kind, logic [31:0] value, logic [30:0] delay);
        int gap;
        gap = gap_length();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_item_in <= value;
        s_delay   <= delay;
        do @(posedge aclk); while (!s_ready);
        board.note_input(kind, value, delay);
        @(negedge aclk);
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (board.pending_q.size() != 0) @(negedge aclk);
    endtask

    function logic [30:0] random_delay();
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'h7FFF_FFFF;
            2: return 31'($urandom);
            default: return 31'($urandom_range(0, 12));
        endcase
    endfunction

    // Result side: random back-pressure outside the calm window, sampled at the rising edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= sink_calm ? 1'b1 : (gap_length() == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result({status_t'(m_status), m_item_out, m_item_valid,
                                m_occupancy, m_time_to_next});
        end
    end

    // Watchdog on a generous cycle budget.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** delay_queue_top: FAILED **");
            $finish;
        end
    end

    initial begin
        int pick;
        board     = new();
        cycles    = 0;
        sink_calm = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_kind    = KIND_TICK;
        s_item_in = '0;
        s_delay   = '0;
        m_ready   = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty poll, full store, not due, due order, extremes, clear.
        send_beat(KIND_POLL, 32'd0, 31'd0);
        send_beat(KIND_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_beat(KIND_POLL, 32'd0, 31'd0);
        send_beat(KIND_ADD, 32'd0, 31'd0);
        send_beat(KIND_ADD, 32'h1234_5678, 31'd0);
        send_beat(KIND_POLL, 32'd0, 31'd0);
        send_beat(KIND_POLL, 32'd0, 31'd0);
        for (int i = 0; i < 16; i++) begin
            send_beat(KIND_ADD, 32'(i) ^ 32'hA5A5_0000, 31'(i % 3));
        end
        send_beat(KIND_ADD, 32'hDEAD_BEEF, 31'd1);
        send_beat(KIND_TICK, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_beat(KIND_POLL, 32'd0, 31'd0);
        send_beat(KIND_CLEAR, 32'd0, 31'd0);

        // The sender holds off until every result has been returned.
        wait_drained();

        // Random: mostly adds, polls and ticks, with the odd clear.
        for (int n = 0; n < NUM_ITEMS; n++) begin
            sink_calm = (n >= 400 && n < 500);
            pick = $urandom_range(0, 99);
            if (pick < 35) send_beat(KIND_ADD, $urandom, random_delay());
            else if (pick < 70) send_beat(KIND_POLL, $urandom, 31'($urandom));
            else if (pick < 97) send_beat(KIND_TICK, $urandom, 31'($urandom));
            else send_beat(KIND_CLEAR, $urandom, 31'($urandom));
            if (n == 600) wait_drained();
        end

        wait_drained();
        repeat (100) @(negedge aclk);
        if (board.mismatches == 0 && board.pending_q.size() == 0) begin
            $display("** delay_queue_top: PASSED **");
        end else begin
            $display("** delay_queue_top: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== delay_queue_top.f =====
+incdir+design
design/dq_pkg.sv
design/dq_ctrl.sv
design/dq_datapath.sv
design/delay_queue_top.sv
test/testbench.sv
